// File: rtl/bdrd_pkg.sv
// shared types and constants for the document run distance block
package bdrd_pkg;

	localparam int DOC_ID_W   = 16;
	localparam int SYM_W      = 8;
	localparam int DIST_W     = 32;
	localparam int SKIP_W     = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;

	localparam logic [SYM_W-1:0] SYM_HASH = 8'h23;

	localparam logic [DOC_ID_W-1:0] DOC_A_RST = 16'd1;
	localparam logic [DOC_ID_W-1:0] DOC_B_RST = 16'd0;

	typedef enum logic [1:0] {
		OWN_NONE = 2'd0,
		OWN_A    = 2'd1,
		OWN_B    = 2'd2
	} bdrd_owner_t;

	typedef enum logic [1:0] {
		REG_DOC_A  = 2'd0,
		REG_DOC_B  = 2'd1,
		REG_SKIP   = 2'd2,
		REG_DOLLAR = 2'd3
	} bdrd_reg_t;

	typedef struct packed {
		logic [DOC_ID_W-1:0] doc_a;
		logic [DOC_ID_W-1:0] doc_b;
		logic [SKIP_W-1:0]   skip_count;
		logic                dollar_joins_run;
	} bdrd_cfg_t;

	typedef struct packed {
		bdrd_owner_t      who;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} bdrd_item_t;

endpackage

// File: rtl/bdrd_entry_if.sv
// input channel carrying one stream entry per transaction
interface bdrd_entry_if;
	import bdrd_pkg::*;

	logic                valid;
	logic                ready;
	logic [DOC_ID_W-1:0] doc_id;
	logic [SYM_W-1:0]    bwt_symbol;
	logic                last_entry;

	modport source (output valid, doc_id, bwt_symbol, last_entry, input ready);
	modport sink (input valid, doc_id, bwt_symbol, last_entry, output ready);

endinterface

// File: rtl/bdrd_result_if.sv
// output channel carrying both distances per transaction
interface bdrd_result_if;
	import bdrd_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] doc_run_distance;
	logic [DIST_W-1:0] bwt_run_distance;

	modport source (output valid, doc_run_distance, bwt_run_distance, input ready);
	modport sink (input valid, doc_run_distance, bwt_run_distance, output ready);

endinterface

// File: rtl/bdrd_cfg.sv
// apb-style configuration register file
module bdrd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bdrd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [bdrd_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [bdrd_pkg::CFG_DATA_W-1:0] prdata,
	output logic                          pready,
	output bdrd_pkg::bdrd_cfg_t           cfg
);
	import bdrd_pkg::*;

	bdrd_cfg_t cfg_q;
	bdrd_reg_t reg_idx;
	logic      wr_en;

	assign reg_idx = bdrd_reg_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.doc_a            <= DOC_A_RST;
			cfg_q.doc_b            <= DOC_B_RST;
			cfg_q.skip_count       <= '0;
			cfg_q.dollar_joins_run <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DOC_A:  cfg_q.doc_a            <= pwdata[DOC_ID_W-1:0];
				REG_DOC_B:  cfg_q.doc_b            <= pwdata[DOC_ID_W-1:0];
				REG_SKIP:   cfg_q.skip_count       <= pwdata[SKIP_W-1:0];
				REG_DOLLAR: cfg_q.dollar_joins_run <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_DOC_A:  prdata = CFG_DATA_W'(cfg_q.doc_a);
			REG_DOC_B:  prdata = CFG_DATA_W'(cfg_q.doc_b);
			REG_SKIP:   prdata = CFG_DATA_W'(cfg_q.skip_count);
			REG_DOLLAR: prdata = CFG_DATA_W'(cfg_q.dollar_joins_run);
			default:    prdata = '0;
		endcase
	end

endmodule

// File: rtl/bdrd_in_stage.sv
// input register: skip counter and document id classification
module bdrd_in_stage #(
	parameter int ID_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bdrd_pkg::bdrd_cfg_t  cfg,
	bdrd_entry_if.sink           entry,
	input  logic                 advance,
	output logic                 valid_s1,
	output bdrd_pkg::bdrd_item_t item_s1
);
	import bdrd_pkg::*;

	localparam int CMP_BITS = (ID_BITS < DOC_ID_W) ? ID_BITS : DOC_ID_W;

	logic [SKIP_W-1:0] position_q;
	logic              accept;
	logic              active;
	bdrd_owner_t       who;

	assign entry.ready = !valid_s1 || advance;
	assign accept      = entry.valid && entry.ready;
	assign active      = position_q >= cfg.skip_count;

	always_comb begin
		who = OWN_NONE;
		if (active) begin
			if (entry.doc_id[CMP_BITS-1:0] == cfg.doc_a[CMP_BITS-1:0]) begin
				who = OWN_A;
			end else if (entry.doc_id[CMP_BITS-1:0] == cfg.doc_b[CMP_BITS-1:0]) begin
				who = OWN_B;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (entry.last_entry) begin
					position_q <= '0;
				end else if (position_q != '1) begin
					position_q <= position_q + SKIP_W'(1);
				end
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.who    <= who;
			item_s1.symbol <= entry.bwt_symbol;
			item_s1.last   <= entry.last_entry;
		end
	end

endmodule

// File: rtl/bdrd_accum.sv
// run tracking, distance sums and result register
module bdrd_accum #(
	parameter int COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 dollar_joins_run,
	input  logic                 valid_s1,
	input  bdrd_pkg::bdrd_item_t item_s1,
	output logic                 advance,
	bdrd_result_if.source        result
);
	import bdrd_pkg::*;

	localparam int CB  = COUNT_BITS;
	localparam int OPW = (COUNT_BITS + 1 > DIST_W + 1) ? COUNT_BITS + 1 : DIST_W + 1;

	function automatic logic [DIST_W-1:0] sat_add(
		input logic [DIST_W-1:0] a,
		input logic [OPW-1:0]    b
	);
		logic [DIST_W:0] s;
		s = {1'b0, a} + {1'b0, b[DIST_W-1:0]};
		if (b[OPW-1:DIST_W] != '0 || s[DIST_W]) begin
			sat_add = '1;
		end else begin
			sat_add = s[DIST_W-1:0];
		end
	endfunction

	bdrd_owner_t       owner_q;
	logic [CB-1:0]     len_q;
	logic [DIST_W-1:0] doc_sum_q;
	logic              run_open_q;
	logic [SYM_W-1:0]  prev_sym_q;
	logic              neg_q;
	logic [CB-1:0]     mag_q;
	logic [DIST_W-1:0] sym_sum_q;
	logic              out_valid_q;
	logic [DIST_W-1:0] doc_dist_q;
	logic [DIST_W-1:0] bwt_dist_q;

	logic              take;
	logic              counted;
	logic              change;
	logic              joins;
	logic              new_run;
	logic              up;
	logic [CB-1:0]     len_n;
	logic [CB-1:0]     base_mag;
	logic              base_neg;
	logic [CB-1:0]     mag_n;
	logic              neg_n;
	logic [OPW-1:0]    doc_op;
	logic [OPW-1:0]    sym_op;
	logic [DIST_W-1:0] doc_sum_n;
	logic [DIST_W-1:0] sym_sum_n;

	assign advance = !out_valid_q || result.ready;
	assign take    = advance && valid_s1;

	assign result.valid            = out_valid_q;
	assign result.doc_run_distance = doc_dist_q;
	assign result.bwt_run_distance = bwt_dist_q;

	always_comb begin
		counted = item_s1.who != OWN_NONE;
		change  = counted && (owner_q != item_s1.who);
		up      = item_s1.who == OWN_A;

		if (change) begin
			len_n = CB'(1);
		end else if (counted && len_q != '1) begin
			len_n = len_q + CB'(1);
		end else begin
			len_n = len_q;
		end

		if (change) begin
			doc_op = OPW'(len_q - CB'(1));
		end else if (item_s1.last) begin
			doc_op = OPW'(len_n - CB'(1));
		end else begin
			doc_op = '0;
		end

		joins = run_open_q && (item_s1.symbol == prev_sym_q ||
			(dollar_joins_run && item_s1.symbol == SYM_HASH));
		new_run  = counted && !joins;
		base_mag = new_run ? '0 : mag_q;
		base_neg = new_run ? 1'b0 : neg_q;

		if (!counted) begin
			mag_n = mag_q;
			neg_n = neg_q;
		end else if (base_mag == '0) begin
			mag_n = CB'(1);
			neg_n = !up;
		end else if (base_neg == !up) begin
			mag_n = (base_mag != '1) ? base_mag + CB'(1) : base_mag;
			neg_n = base_neg;
		end else begin
			mag_n = base_mag - CB'(1);
			neg_n = (base_mag == CB'(1)) ? 1'b0 : base_neg;
		end

		if (new_run) begin
			sym_op = OPW'(mag_q) + OPW'(item_s1.last);
		end else if (item_s1.last) begin
			sym_op = OPW'(mag_n);
		end else begin
			sym_op = '0;
		end

		doc_sum_n = sat_add(doc_sum_q, doc_op);
		sym_sum_n = sat_add(sym_sum_q, sym_op);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_q     <= OWN_NONE;
			len_q       <= CB'(1);
			doc_sum_q   <= '0;
			run_open_q  <= 1'b0;
			prev_sym_q  <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			sym_sum_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && item_s1.last) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (item_s1.last) begin
					owner_q    <= OWN_NONE;
					len_q      <= CB'(1);
					doc_sum_q  <= '0;
					run_open_q <= 1'b0;
					prev_sym_q <= '0;
					neg_q      <= 1'b0;
					mag_q      <= '0;
					sym_sum_q  <= '0;
				end else begin
					owner_q    <= counted ? item_s1.who : owner_q;
					len_q      <= len_n;
					doc_sum_q  <= doc_sum_n;
					run_open_q <= run_open_q || counted;
					prev_sym_q <= new_run ? item_s1.symbol : prev_sym_q;
					neg_q      <= neg_n;
					mag_q      <= mag_n;
					sym_sum_q  <= sym_sum_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last) begin
			doc_dist_q <= doc_sum_n;
			bwt_dist_q <= sym_sum_n;
		end
	end

endmodule

// File: rtl/bwt_document_run_distance.sv
// top level: document run and bwt run distance between two documents
// the last accepted entry moves from the input register into the result register
// throughput: one entry per cycle unless a held result stalls; the input register
// and run state update stage take one per clock, the result register parts output
// reset: registers take their reset values, run state and skip position clear
// and the block is ready for entries once reset is released
module bwt_document_run_distance #(
	parameter int ID_BITS    = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bdrd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [bdrd_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [bdrd_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	bdrd_entry_if.sink                      entry,
	bdrd_result_if.source                   result
);
	import bdrd_pkg::*;

	bdrd_cfg_t  cfg;
	logic       advance;
	logic       valid_s1;
	bdrd_item_t item_s1;

	bdrd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdrd_in_stage #(
		.ID_BITS (ID_BITS)
	) u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.entry    (entry),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bdrd_accum #(
		.COUNT_BITS (COUNT_BITS)
	) u_accum (
		.clk              (clk),
		.arst_n           (arst_n),
		.dollar_joins_run (cfg.dollar_joins_run),
		.valid_s1         (valid_s1),
		.item_s1          (item_s1),
		.advance          (advance),
		.result           (result)
	);

`ifndef SYNTH
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && item_s1.last && advance |=> result.valid)
		else $error("last entry did not produce a result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result.valid |-> entry.ready)
		else $error("input stalled with empty result register");

	a_last_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		entry.valid && entry.ready && entry.last_entry |=> valid_s1 && item_s1.last)
		else $error("accepted last entry missing from input register");
`endif

endmodule
